[rtl/sprite_animation_sequencer_top_macros.svh]
// ----------------------------------------------------------------------------
// Sprite animation sequencer - assertion macros
// Concurrent checks used at the end of the top level; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIMATION_SEQUENCER_TOP_MACROS_SVH
`define SPRITE_ANIMATION_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property that holds on every edge outside reset
`define SAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle implies the consequent in the next
`define SAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SAS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/sas_pkg.sv]
// ----------------------------------------------------------------------------
// sas_pkg
// Types, sizes and helpers shared by the sprite animation sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sas_pkg;

    localparam int MAX_ANIMS  = 16;
    localparam int MAX_FRAMES = 16;

    localparam int ANIM_W    = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
    localparam int FRAME_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RAM_DEPTH = MAX_ANIMS * MAX_FRAMES;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int SPRITE_W  = 16;
    localparam int DELAY_W   = 16;
    localparam int ENTRY_W   = SPRITE_W + DELAY_W;

    typedef enum logic [1:0] {
        OP_LOAD_FRAME = 2'd0,
        OP_LOAD_ID    = 2'd1,
        OP_SELECT     = 2'd2,
        OP_TICK       = 2'd3
    } op_t;

    typedef enum logic {
        ST_OK        = 1'b0,
        ST_NOT_FOUND = 1'b1
    } status_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  anim_slot;
        logic [3:0]  frame_slot;
        logic [15:0] anim_id;
        logic [15:0] sprite_code;
        logic [15:0] frame_delay;
    } req_t;

    typedef struct packed {
        logic [15:0] draw_sprite;
        logic [3:0]  play_slot;
        logic [3:0]  frame_index;
        status_t     status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SEL_LOAD,
        S_TICK_CHECK,
        S_TICK_WRAP
    } state_t;

    // Frame store read address source
    typedef enum logic [1:0] {
        RD_TICK_NEXT,
        RD_TICK_FIRST,
        RD_SEL_FIRST
    } rd_src_t;

    typedef enum logic {
        EMIT_CURRENT,
        EMIT_SELECTED
    } emit_src_t;

    // Update of the playing animation state
    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_DEC,
        CUR_SELECT,
        CUR_STEP,
        CUR_WRAP
    } cur_op_t;

    typedef struct packed {
        logic      id_wr;
        logic      ram_wr;
        logic      srch_clr;
        logic      srch_inc;
        logic      pend_ld;
        logic      emit;
        emit_src_t emit_src;
        status_t   emit_status;
        rd_src_t   rd_src;
        cur_op_t   cur_op;
    } dp_cmd_t;

    typedef struct packed {
        op_t               op;
        logic              delay_zero;
        logic              delay_one;
        logic              id_zero;
        logic              id_match;
        logic              srch_last;
        logic              rd_sprite_zero;
        logic              pend_zero;
        logic              out_free;
        logic [ANIM_W-1:0] srch_idx;
    } dp_stat_t;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [ANIM_W-1:0] anim,
                                                     input logic [FRAME_W-1:0] frame);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ADDR_W'(anim) * ADDR_W'(MAX_FRAMES));
        return base + ADDR_W'(frame);
    endfunction

endpackage

`default_nettype wire

[rtl/sas_ram.sv]
// ----------------------------------------------------------------------------
// sas_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/sas_dp.sv]
// ----------------------------------------------------------------------------
// sas_dp
// Datapath: id table, frame store, playing state, search index and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sas_pkg::req_t    req,
    input  wire sas_pkg::dp_cmd_t cmd,
    output sas_pkg::dp_stat_t     stat,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output sas_pkg::rsp_t         rsp
);

    import sas_pkg::*;

    logic [15:0]          id_table_reg [MAX_ANIMS];
    logic [RAM_DEPTH-1:0] valid_reg;
    logic [ANIM_W-1:0]    cur_anim_reg,   cur_anim_next;
    logic [FRAME_W-1:0]   cur_frame_reg,  cur_frame_next;
    logic [SPRITE_W-1:0]  cur_sprite_reg, cur_sprite_next;
    logic [DELAY_W-1:0]   delay_reg,      delay_next;
    logic [ANIM_W-1:0]    srch_idx_reg,   srch_idx_next;
    logic [15:0]          key_reg;
    logic [FRAME_W-1:0]   pend_frame_reg;
    logic                 vrd_reg;
    logic                 rsp_valid_reg,  rsp_valid_next;
    rsp_t                 rsp_reg,        rsp_next;

    logic                 slot_ok;
    logic                 id_slot_ok;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]   rd_data;
    logic [SPRITE_W-1:0]  rd_sprite;
    logic [DELAY_W-1:0]   rd_delay;
    logic [FRAME_W-1:0]   next_frame;
    logic [15:0]          id_cur;

    assign id_slot_ok = int'(req.anim_slot) < MAX_ANIMS;
    assign slot_ok    = id_slot_ok && (int'(req.frame_slot) < MAX_FRAMES);
    assign wr_addr    = slot_addr(ANIM_W'(req.anim_slot), FRAME_W'(req.frame_slot));

    // Wrap at the last position of a list
    assign next_frame = (cur_frame_reg == FRAME_W'(MAX_FRAMES - 1)) ? '0
                                                                    : cur_frame_reg + 1'b1;

    always_comb
    begin
        unique case (cmd.rd_src)
            RD_TICK_NEXT:  rd_addr = slot_addr(cur_anim_reg, next_frame);
            RD_TICK_FIRST: rd_addr = slot_addr(cur_anim_reg, '0);
            RD_SEL_FIRST:  rd_addr = slot_addr(srch_idx_reg, '0);
            default:       rd_addr = slot_addr(cur_anim_reg, next_frame);
        endcase
    end

    sas_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (cmd.ram_wr && slot_ok),
        .wr_addr (wr_addr),
        .wr_data ({req.sprite_code, req.frame_delay}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Never-written entries read as zero
    assign rd_sprite = vrd_reg ? rd_data[ENTRY_W-1:DELAY_W] : '0;
    assign rd_delay  = vrd_reg ? rd_data[DELAY_W-1:0]       : '0;

    assign id_cur = id_table_reg[srch_idx_reg];

    always_comb
    begin
        stat.op             = req.op;
        stat.delay_zero     = (delay_reg == '0);
        stat.delay_one      = (delay_reg == DELAY_W'(1));
        stat.id_zero        = (id_cur == '0);
        stat.id_match       = (id_cur == key_reg);
        stat.srch_last      = (srch_idx_reg == ANIM_W'(MAX_ANIMS - 1));
        stat.rd_sprite_zero = (rd_sprite == '0);
        stat.pend_zero      = (pend_frame_reg == '0);
        stat.out_free       = !rsp_valid_reg || !rsp_stall;
        stat.srch_idx       = srch_idx_reg;
    end

    always_comb
    begin
        cur_anim_next   = cur_anim_reg;
        cur_frame_next  = cur_frame_reg;
        cur_sprite_next = cur_sprite_reg;
        delay_next      = delay_reg;
        unique case (cmd.cur_op)
            CUR_HOLD: ;
            CUR_DEC:  delay_next = delay_reg - 1'b1;
            CUR_SELECT:
            begin
                cur_anim_next   = srch_idx_reg;
                cur_frame_next  = '0;
                cur_sprite_next = rd_sprite;
                delay_next      = rd_delay;
            end
            CUR_STEP:
            begin
                cur_frame_next  = pend_frame_reg;
                cur_sprite_next = rd_sprite;
                delay_next      = rd_delay;
            end
            CUR_WRAP:
            begin
                cur_frame_next  = '0;
                cur_sprite_next = rd_sprite;
                delay_next      = rd_delay;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        priority if (cmd.srch_clr)
        begin
            srch_idx_next = '0;
        end
        else if (cmd.srch_inc)
        begin
            srch_idx_next = srch_idx_reg + 1'b1;
        end
        else
        begin
            srch_idx_next = srch_idx_reg;
        end
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.emit)
        begin
            rsp_next.status = cmd.emit_status;
            unique case (cmd.emit_src)
                EMIT_CURRENT:
                begin
                    rsp_next.draw_sprite = cur_sprite_reg;
                    rsp_next.play_slot   = 4'(cur_anim_reg);
                    rsp_next.frame_index = 4'(cur_frame_reg);
                end
                EMIT_SELECTED:
                begin
                    rsp_next.draw_sprite = rd_sprite;
                    rsp_next.play_slot   = 4'(srch_idx_reg);
                    rsp_next.frame_index = '0;
                end
                default: ;
            endcase
        end
        rsp_valid_next = cmd.emit || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ANIMS; i++)
            begin
                id_table_reg[i] <= '0;
            end
            valid_reg      <= '0;
            cur_anim_reg   <= '0;
            cur_frame_reg  <= '0;
            cur_sprite_reg <= '0;
            delay_reg      <= '0;
            srch_idx_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.id_wr && id_slot_ok)
            begin
                id_table_reg[ANIM_W'(req.anim_slot)] <= req.anim_id;
            end
            if (cmd.ram_wr && slot_ok)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            cur_anim_reg   <= cur_anim_next;
            cur_frame_reg  <= cur_frame_next;
            cur_sprite_reg <= cur_sprite_next;
            delay_reg      <= delay_next;
            srch_idx_reg   <= srch_idx_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.srch_clr)
        begin
            key_reg <= req.anim_id;
        end
        if (cmd.pend_ld)
        begin
            pend_frame_reg <= next_frame;
        end
        vrd_reg <= valid_reg[rd_addr];
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[rtl/sas_ctrl.sv]
// ----------------------------------------------------------------------------
// sas_ctrl
// Controller: sequences loads, the id search and the frame step of a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire sas_pkg::dp_stat_t stat,
    output sas_pkg::dp_cmd_t       cmd,
    output sas_pkg::state_t        state
);

    import sas_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign req_stall = !((state_reg == S_IDLE) && stat.out_free);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stat.op == OP_SELECT)
                    begin
                        state_next = S_SEARCH;
                    end
                    else if (stat.op == OP_TICK && stat.delay_one)
                    begin
                        state_next = S_TICK_CHECK;
                    end
                end
            end
            S_SEARCH:
            begin
                priority if (stat.id_zero)
                begin
                    if (stat.out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (stat.id_match)
                begin
                    state_next = S_SEL_LOAD;
                end
                else if (stat.srch_last)
                begin
                    if (stat.out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // keep walking the table
                    state_next = S_SEARCH;
                end
            end
            S_SEL_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK_CHECK:
            begin
                if (stat.rd_sprite_zero && !stat.pend_zero)
                begin
                    state_next = S_TICK_WRAP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK_WRAP: state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.emit_src    = EMIT_CURRENT;
        cmd.emit_status = ST_OK;
        cmd.rd_src      = RD_TICK_NEXT;
        cmd.cur_op      = CUR_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (stat.op)
                        OP_LOAD_FRAME:
                        begin
                            cmd.ram_wr = 1'b1;
                            cmd.emit   = 1'b1;
                        end
                        OP_LOAD_ID:
                        begin
                            cmd.id_wr = 1'b1;
                            cmd.emit  = 1'b1;
                        end
                        OP_SELECT: cmd.srch_clr = 1'b1;
                        OP_TICK:
                        begin
                            cmd.emit = 1'b1;
                            priority if (stat.delay_zero)
                            begin
                                cmd.cur_op = CUR_HOLD;
                            end
                            else if (stat.delay_one)
                            begin
                                cmd.pend_ld = 1'b1;
                            end
                            else
                            begin
                                cmd.cur_op = CUR_DEC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH:
            begin
                cmd.rd_src = RD_SEL_FIRST;
                priority if (stat.id_zero || (!stat.id_match && stat.srch_last))
                begin
                    cmd.emit        = stat.out_free;
                    cmd.emit_status = ST_NOT_FOUND;
                end
                else if (!stat.id_match)
                begin
                    cmd.srch_inc = 1'b1;
                end
                else
                begin
                    // hold the index on a match
                    cmd.srch_inc = 1'b0;
                end
            end
            S_SEL_LOAD:
            begin
                cmd.rd_src = RD_SEL_FIRST;
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = EMIT_SELECTED;
                    cmd.cur_op   = CUR_SELECT;
                end
            end
            S_TICK_CHECK:
            begin
                cmd.rd_src = RD_TICK_FIRST;
                if (!(stat.rd_sprite_zero && !stat.pend_zero))
                begin
                    cmd.cur_op = CUR_STEP;
                end
            end
            S_TICK_WRAP: cmd.cur_op = CUR_WRAP;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

[rtl/sprite_animation_sequencer_top.sv]
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_top
// Sprite frame animation sequencer: id table, frame lists and frame stepping.
// ----------------------------------------------------------------------------
// Use: one request channel (req_valid / req_stall / req) carries load frame,
// load id, select by id and tick items; one response channel (rsp_valid /
// rsp_stall / rsp) returns exactly one result item for each request item.
// An item is taken at a rising edge with valid high and stall low.
// Timing: the result of a load or tick is written to the output register
// as the item is accepted. A tick that moves to a new frame keeps the block
// busy in S_TICK_CHECK, where the next entry read from the frame store is
// checked, and also in S_TICK_WRAP, where frame 0 is read when the list wraps.
// A select compares one id table entry per cycle in S_SEARCH, up to MAX_ANIMS
// entries, and on a match takes the first frame from the store in S_SEL_LOAD.
// The id walk is the longest case; a new item is taken only once the last is done.
// Reset: asynchronous, active low; the id table, the frame store valid bits
// and the playing state clear at once, with no clearing pass.
// Stall: a pending result holds in the output register; a new item is taken
// only while the controller is idle and the output register can accept.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sprite_animation_sequencer_top_macros.svh"

module sprite_animation_sequencer_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire sas_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output sas_pkg::rsp_t      rsp
);

    import sas_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    state_t   state;

    // Controller: decides per cycle what the datapath does
    sas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd),
        .state     (state)
    );

    // Datapath: tables, frame store, playing state and the result register
    sas_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // A result is only written when the output register has room
    `SAS_ASSERT(a_emit_room, clk, rst_n, cmd.emit |-> stat.out_free, "result written while output register is full")

    // The id walk never leaves the table
    `SAS_ASSERT(a_search_bound, clk, rst_n, (state == S_SEARCH) |-> (int'(stat.srch_idx) < MAX_ANIMS), "search index beyond id table")

    // Load items finish in the cycle they are taken
    `SAS_ASSERT_NEXT(a_load_one_cycle, clk, rst_n, req_valid && !req_stall && (req.op == OP_LOAD_FRAME || req.op == OP_LOAD_ID), state == S_IDLE, "load item left controller busy")

    // The playing frame is reloaded from the store only off the idle state
    `SAS_ASSERT(a_reload_busy, clk, rst_n, (cmd.cur_op == CUR_SELECT || cmd.cur_op == CUR_STEP || cmd.cur_op == CUR_WRAP) |-> (state != S_IDLE), "frame reload issued while idle")

endmodule

`default_nettype wire

[tb/tb_sprite_animation_sequencer_top.sv]
// ----------------------------------------------------------------------------
// tb_sprite_animation_sequencer_top
// Self-checking bench for the sprite animation sequencer. A scoreboard class
// tracks the id table, the frame stores and the playing state, predicts one
// result per accepted request item and checks each accepted result item in
// order. Directed items come first, then randomised load/select/tick scenes
// mixed with noise, under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sprite_animation_sequencer_top;
    import sas_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int HOLD_LEN     = 150;   // long receiver hold-off, in cycles
    localparam int RANDOM_ITEMS = 400;
    localparam int SETTLE       = MAX_ANIMS + 4;
    localparam int REPORT_MAX   = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the tables and the playing animation,
    // queues the result each request item should produce and checks results.
    // ------------------------------------------------------------------------
    class playback_scoreboard;
        logic [15:0] id_slots   [MAX_ANIMS];
        logic [15:0] sprite_mem [MAX_ANIMS * MAX_FRAMES];
        logic [15:0] delay_mem  [MAX_ANIMS * MAX_FRAMES];
        logic [3:0]  play_anim;
        logic [3:0]  play_frame;
        logic [15:0] play_sprite;
        logic [15:0] ticks_left;
        rsp_t        pending_draws[$];
        int          mismatches;
        int          unexpected;
        int          checked;
        int          n_found;
        int          n_missed;
        int          n_steps;
        int          n_list_wraps;
        int          n_full_wraps;
        int          n_holds;

        function new();
            foreach (id_slots[i]) id_slots[i] = '0;
            foreach (sprite_mem[i]) sprite_mem[i] = '0;
            foreach (delay_mem[i]) delay_mem[i] = '0;
            play_anim    = '0;
            play_frame   = '0;
            play_sprite  = '0;
            ticks_left   = '0;
            mismatches   = 0;
            unexpected   = 0;
            checked      = 0;
            n_found      = 0;
            n_missed     = 0;
            n_steps      = 0;
            n_list_wraps = 0;
            n_full_wraps = 0;
            n_holds      = 0;
        endfunction

        function int entry(input int anim, input int frame);
            return anim * MAX_FRAMES + frame;
        endfunction

        function int pending();
            return pending_draws.size();
        endfunction

        // Work out the result of one accepted request item and queue it
        function void take_request(input req_t it);
            rsp_t want;
            int   i;
            int   nf;
            want.status = ST_OK;
            // a tick reports the state from before the step
            want.draw_sprite = play_sprite;
            want.play_slot   = play_anim;
            want.frame_index = play_frame;
            case (it.op)
                OP_LOAD_FRAME:
                begin
                    sprite_mem[entry(it.anim_slot, it.frame_slot)] = it.sprite_code;
                    delay_mem[entry(it.anim_slot, it.frame_slot)]  = it.frame_delay;
                end
                OP_LOAD_ID:
                begin
                    id_slots[it.anim_slot] = it.anim_id;
                end
                OP_SELECT:
                begin
                    // walk from slot 0; a zero id ends the table
                    i = 0;
                    while (i < MAX_ANIMS && id_slots[i] != '0 && id_slots[i] != it.anim_id)
                        i++;
                    if (i < MAX_ANIMS && id_slots[i] != '0)
                    begin
                        play_anim   = 4'(i);
                        play_frame  = '0;
                        play_sprite = sprite_mem[entry(i, 0)];
                        ticks_left  = delay_mem[entry(i, 0)];
                        n_found++;
                    end
                    else
                    begin
                        want.status = ST_NOT_FOUND;
                        n_missed++;
                    end
                    want.draw_sprite = play_sprite;
                    want.play_slot   = play_anim;
                    want.frame_index = play_frame;
                end
                OP_TICK:
                begin
                    if (ticks_left == 16'd0)
                    begin
                        n_holds++;
                    end
                    else if (ticks_left == 16'd1)
                    begin
                        nf = int'(play_frame) + 1;
                        if (nf >= MAX_FRAMES)
                        begin
                            nf = 0;
                            n_full_wraps++;
                        end
                        else if (sprite_mem[entry(play_anim, nf)] == '0)
                        begin
                            nf = 0;
                            n_list_wraps++;
                        end
                        play_frame  = 4'(nf);
                        play_sprite = sprite_mem[entry(play_anim, nf)];
                        ticks_left  = delay_mem[entry(play_anim, nf)];
                        n_steps++;
                    end
                    else
                    begin
                        ticks_left = ticks_left - 16'd1;
                    end
                end
            endcase
            pending_draws.push_back(want);
        endfunction

        // Compare one accepted result item with the oldest prediction
        function void match_response(input rsp_t got);
            rsp_t want;
            if (pending_draws.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= REPORT_MAX)
                    $display("unexpected result: sprite %h anim %0d frame %0d status %0d",
                             got.draw_sprite, got.play_slot, got.frame_index, got.status);
                return;
            end
            want = pending_draws.pop_front();
            checked++;
            if (got.draw_sprite !== want.draw_sprite || got.play_slot !== want.play_slot ||
                got.frame_index !== want.frame_index || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches + unexpected <= REPORT_MAX)
                    $display("mismatch at result %0d: want sprite %h anim %0d frame %0d st %0d,",
                             checked, want.draw_sprite, want.play_slot, want.frame_index,
                             want.status,
                             " got sprite %h anim %0d frame %0d st %0d",
                             got.draw_sprite, got.play_slot, got.frame_index, got.status);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    playback_scoreboard sb;
    int send_idle;
    int recv_idle;
    int items_sent;
    bit hold_off_due;

    sprite_animation_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Guard against a hung handshake
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one item, after a random gap, and hold it until it is taken.
    // Signals are sampled straight after the edge, so they carry their
    // pre-edge values.
    task automatic send_item(input req_t it);
        if ($urandom_range(0, 99) < send_idle)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        req       <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sb.take_request(it);
        items_sent++;
    endtask

    task automatic send_fields(input op_t op, input logic [3:0] aslot,
                               input logic [3:0] fslot, input logic [15:0] aid,
                               input logic [15:0] spr, input logic [15:0] dly);
        req_t it;
        it.op          = op;
        it.anim_slot   = aslot;
        it.frame_slot  = fslot;
        it.anim_id     = aid;
        it.sprite_code = spr;
        it.frame_delay = dly;
        send_item(it);
    endtask

    // Fully random item: any op, any field value
    task automatic send_noise();
        req_t it;
        it.op          = op_t'($urandom_range(0, 3));
        it.anim_slot   = 4'($urandom);
        it.frame_slot  = 4'($urandom);
        it.anim_id     = 16'($urandom);
        it.sprite_code = 16'($urandom);
        it.frame_delay = 16'($urandom);
        send_item(it);
    endtask

    // Drop valid and pause until every result is back and the block is idle
    task automatic drain_results();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One well-formed scene: make the id reachable, load a frame list (with
    // its terminator when shorter than MAX_FRAMES), select it and tick through
    // it. Now and then slip a stray item in to break the sequence.
    task automatic run_scene();
        int          slot;
        int          len;
        int          nticks;
        int          r;
        logic [15:0] dly;
        slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_ANIMS - 1)
                                            : $urandom_range(0, 5);
        // fill any zero id up to and including the target so the walk reaches it
        for (int j = 0; j <= slot; j++)
            if (sb.id_slots[j] == '0 || (j == slot && $urandom_range(0, 2) == 0))
                send_fields(OP_LOAD_ID, 4'(j), 4'($urandom), 16'($urandom_range(1, 65535)),
                            16'($urandom), 16'($urandom));
        len = ($urandom_range(0, 4) == 0) ? MAX_FRAMES : $urandom_range(1, 6);
        for (int f = 0; f < len; f++)
        begin
            r = $urandom_range(0, 9);
            if (len == MAX_FRAMES && r < 7)
                dly = 16'd1;
            else if (r == 0)
                dly = 16'd0;
            else if (r == 9)
                dly = 16'($urandom_range(4, 24));
            else
                dly = 16'($urandom_range(1, 3));
            send_fields(OP_LOAD_FRAME, 4'(slot), 4'(f), 16'($urandom),
                        16'($urandom_range(1, 65535)), dly);
            if ($urandom_range(0, 19) == 0)
                send_noise();
        end
        if (len < MAX_FRAMES)
            send_fields(OP_LOAD_FRAME, 4'(slot), 4'(len), 16'($urandom), 16'd0,
                        16'($urandom));
        send_fields(OP_SELECT, 4'($urandom), 4'($urandom), sb.id_slots[slot],
                    16'($urandom), 16'($urandom));
        nticks = $urandom_range(2, 3 * len + 6);
        for (int t = 0; t < nticks; t++)
        begin
            send_fields(OP_TICK, 4'($urandom), 4'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
            if ($urandom_range(0, 29) == 0)
                send_noise();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int  base;
        int  quota;
        bit  hold_done;
        sb           = new();
        items_sent   = 0;
        hold_off_due = 1'b0;
        hold_done    = 1'b0;
        send_idle    = 23;
        recv_idle    = 71;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset state, id zero, extremes, hold, count-down,
        // advance, wrap at the terminator, empty animation, not found,
        // loads leaving the playing frame alone
        send_fields(OP_TICK,       4'd0,  4'd0,  16'h0000, 16'h0000, 16'h0000);
        send_fields(OP_SELECT,     4'd0,  4'd0,  16'h0000, 16'h0000, 16'h0000);
        send_fields(OP_LOAD_ID,    4'd0,  4'd0,  16'hFFFF, 16'h0000, 16'h0000);
        send_fields(OP_LOAD_ID,    4'd1,  4'd15, 16'h0001, 16'hFFFF, 16'hFFFF);
        send_fields(OP_LOAD_FRAME, 4'd0,  4'd0,  16'h0000, 16'hFFFF, 16'h0001);
        send_fields(OP_LOAD_FRAME, 4'd0,  4'd1,  16'h0000, 16'h0001, 16'h0002);
        send_fields(OP_LOAD_FRAME, 4'd0,  4'd15, 16'h0000, 16'h8000, 16'hFFFF);
        send_fields(OP_LOAD_FRAME, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_fields(OP_LOAD_ID,    4'd15, 4'd0,  16'hABCD, 16'h0000, 16'h0000);
        send_fields(OP_SELECT,     4'd0,  4'd0,  16'hFFFF, 16'h0000, 16'h0000);
        repeat (4)
            send_fields(OP_TICK,   4'd0,  4'd0,  16'h0000, 16'h0000, 16'h0000);
        send_fields(OP_SELECT,     4'd0,  4'd0,  16'h0001, 16'h0000, 16'h0000);
        send_fields(OP_TICK,       4'd0,  4'd0,  16'h0000, 16'h0000, 16'h0000);
        send_fields(OP_SELECT,     4'd0,  4'd0,  16'hABCD, 16'h0000, 16'h0000);
        send_fields(OP_SELECT,     4'd0,  4'd0,  16'h1234, 16'h0000, 16'h0000);
        send_fields(OP_LOAD_FRAME, 4'd1,  4'd0,  16'h0000, 16'h0001, 16'h0000);
        send_fields(OP_TICK,       4'd0,  4'd0,  16'h0000, 16'h0000, 16'h0000);
        send_fields(OP_SELECT,     4'd0,  4'd0,  16'h0001, 16'h0000, 16'h0000);
        send_fields(OP_TICK,       4'd0,  4'd0,  16'h0000, 16'h0000, 16'h0000);
        drain_results();

        // Random: three idling mixes, pausing for all results between them
        base = items_sent;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin send_idle = 23; recv_idle = 71; end
                1:       begin send_idle = 71; recv_idle = 23; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            quota = base + (RANDOM_ITEMS * (phase + 1)) / 3;
            while (items_sent < quota)
            begin
                // ask for the long hold-off once, while items keep flowing
                if (!hold_done && items_sent - base > 60)
                begin
                    hold_off_due = 1'b1;
                    hold_done    = 1'b1;
                end
                if ($urandom_range(0, 99) < 12)
                    send_noise();
                else
                    run_scene();
            end
            drain_results();
        end

        $display("Ran %0d items: %0d selects found, %0d missed, %0d frame steps, %0d held ticks.",
                 items_sent, sb.n_found, sb.n_missed, sb.n_steps, sb.n_holds);
        $display("Wraps at list end %0d, at last frame %0d;",
                 sb.n_list_wraps, sb.n_full_wraps,
                 " %0d results checked, %0d bad, %0d stray.",
                 sb.checked, sb.mismatches, sb.unexpected);
        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check each accepted result item, then choose the stall for
    // the next cycle. A requested hold-off is counted down here.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                sb.match_response(rsp);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (hold_off_due)
            begin
                hold_off_due = 1'b0;
                hold_left    = HOLD_LEN;
                rsp_stall   <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < recv_idle);
            end
        end
    end

endmodule

`default_nettype wire
